FILE: rtl/vat_pkg.sv
// vat_pkg: shared types, register and mode codes, and the sine table for the vertex transform
// depends on: nothing
package vat_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF   = 14;
	localparam int TABLE_FRAC      = 14;
	localparam int PARAM_W         = 16;
	localparam int ANGLE_W         = 9;
	localparam int MODE_W          = 3;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int RES_W           = 32;
	localparam int LANES           = 4;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PARAM_X = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PARAM_Y = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PARAM_Z = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ANGLE   = 3'd4;

	localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT_X     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROT_Y     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROT_Z     = 3'd4;

	typedef enum logic [2:0] {
		OP_TRANSLATE,
		OP_SCALE,
		OP_ROT_X,
		OP_ROT_Y,
		OP_ROT_Z,
		OP_IDENT
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		logic last;
	} ctrl_t;

	// signed width of a rotation coefficient, and of any matrix coefficient
	function automatic int trig_w(input int frac);
		return frac + 2;
	endfunction

	function automatic int coef_w(input int frac);
		return (frac + 2 > PARAM_W) ? frac + 2 : PARAM_W;
	endfunction

	// round(16384 * sin(d degrees)) for d = 0..90
	function automatic logic [14:0] sine_q14(input logic [6:0] d);
		logic [14:0] v;
		case (d)
			7'd0: v = 15'd0;         7'd1: v = 15'd286;       7'd2: v = 15'd572;
			7'd3: v = 15'd857;       7'd4: v = 15'd1143;      7'd5: v = 15'd1428;
			7'd6: v = 15'd1713;      7'd7: v = 15'd1997;      7'd8: v = 15'd2280;
			7'd9: v = 15'd2563;      7'd10: v = 15'd2845;     7'd11: v = 15'd3126;
			7'd12: v = 15'd3406;     7'd13: v = 15'd3686;     7'd14: v = 15'd3964;
			7'd15: v = 15'd4240;     7'd16: v = 15'd4516;     7'd17: v = 15'd4790;
			7'd18: v = 15'd5063;     7'd19: v = 15'd5334;     7'd20: v = 15'd5604;
			7'd21: v = 15'd5872;     7'd22: v = 15'd6138;     7'd23: v = 15'd6402;
			7'd24: v = 15'd6664;     7'd25: v = 15'd6924;     7'd26: v = 15'd7182;
			7'd27: v = 15'd7438;     7'd28: v = 15'd7692;     7'd29: v = 15'd7943;
			7'd30: v = 15'd8192;     7'd31: v = 15'd8438;     7'd32: v = 15'd8682;
			7'd33: v = 15'd8923;     7'd34: v = 15'd9162;     7'd35: v = 15'd9397;
			7'd36: v = 15'd9630;     7'd37: v = 15'd9860;     7'd38: v = 15'd10087;
			7'd39: v = 15'd10311;    7'd40: v = 15'd10531;    7'd41: v = 15'd10749;
			7'd42: v = 15'd10963;    7'd43: v = 15'd11174;    7'd44: v = 15'd11381;
			7'd45: v = 15'd11585;    7'd46: v = 15'd11786;    7'd47: v = 15'd11982;
			7'd48: v = 15'd12176;    7'd49: v = 15'd12365;    7'd50: v = 15'd12551;
			7'd51: v = 15'd12733;    7'd52: v = 15'd12911;    7'd53: v = 15'd13085;
			7'd54: v = 15'd13255;    7'd55: v = 15'd13421;    7'd56: v = 15'd13583;
			7'd57: v = 15'd13741;    7'd58: v = 15'd13894;    7'd59: v = 15'd14044;
			7'd60: v = 15'd14189;    7'd61: v = 15'd14330;    7'd62: v = 15'd14466;
			7'd63: v = 15'd14598;    7'd64: v = 15'd14726;    7'd65: v = 15'd14849;
			7'd66: v = 15'd14968;    7'd67: v = 15'd15082;    7'd68: v = 15'd15191;
			7'd69: v = 15'd15296;    7'd70: v = 15'd15396;    7'd71: v = 15'd15491;
			7'd72: v = 15'd15582;    7'd73: v = 15'd15668;    7'd74: v = 15'd15749;
			7'd75: v = 15'd15826;    7'd76: v = 15'd15897;    7'd77: v = 15'd15964;
			7'd78: v = 15'd16026;    7'd79: v = 15'd16083;    7'd80: v = 15'd16135;
			7'd81: v = 15'd16182;    7'd82: v = 15'd16225;    7'd83: v = 15'd16262;
			7'd84: v = 15'd16294;    7'd85: v = 15'd16322;    7'd86: v = 15'd16344;
			7'd87: v = 15'd16362;    7'd88: v = 15'd16374;    7'd89: v = 15'd16382;
			7'd90: v = 15'd16384;
			default: v = 15'd0;
		endcase
		return v;
	endfunction

	// signed Q2.14 sine of an angle already reduced below 360
	function automatic logic signed [15:0] sine_fold(input logic [ANGLE_W-1:0] d);
		logic [6:0]         idx;
		logic               neg;
		logic signed [15:0] mag;
		if (d <= 9'd90) begin
			idx = d[6:0];
			neg = 1'b0;
		end else if (d <= 9'd180) begin
			idx = 7'(9'd180 - d);
			neg = 1'b0;
		end else if (d <= 9'd270) begin
			idx = 7'(d - 9'd180);
			neg = 1'b1;
		end else begin
			idx = 7'(9'd360 - d);
			neg = 1'b1;
		end
		mag = $signed({1'b0, sine_q14(idx)});
		return neg ? -mag : mag;
	endfunction

endpackage

FILE: rtl/vat_front.sv
// vat_front: input register stage; mode decode, sine/cosine lookup and multiplier operand select
// depends on: vat_pkg
module vat_front #(
	parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [COORD_WIDTH-1:0]         x_in,
	input  logic signed [COORD_WIDTH-1:0]         y_in,
	input  logic signed [COORD_WIDTH-1:0]         z_in,
	input  logic signed [COORD_WIDTH-1:0]         w_in,
	input  logic                                  last_vertex,
	input  logic [vat_pkg::MODE_W-1:0]            mode_q,
	input  logic signed [vat_pkg::PARAM_W-1:0]    param_x_q,
	input  logic signed [vat_pkg::PARAM_W-1:0]    param_y_q,
	input  logic signed [vat_pkg::PARAM_W-1:0]    param_z_q,
	input  logic [vat_pkg::ANGLE_W-1:0]           angle_q,
	output vat_pkg::ctrl_t                        ctrl_s1,
	output logic signed [vat_pkg::coef_w(FRAC_BITS)-1:0] coef_s1 [vat_pkg::LANES],
	output logic signed [COORD_WIDTH-1:0]         opnd_s1 [vat_pkg::LANES],
	output logic signed [COORD_WIDTH-1:0]         vtx_s1 [vat_pkg::LANES]
);

	localparam int COEF_W = vat_pkg::coef_w(FRAC_BITS);
	localparam int TRIG_W = vat_pkg::trig_w(FRAC_BITS);

	logic [vat_pkg::ANGLE_W-1:0]   ang_s;
	logic [vat_pkg::ANGLE_W:0]     ang_c_wide;
	logic [vat_pkg::ANGLE_W-1:0]   ang_c;
	logic signed [15:0]            sin_t;
	logic signed [15:0]            cos_t;
	logic signed [TRIG_W-1:0]      sin_f;
	logic signed [TRIG_W-1:0]      cos_f;
	logic signed [COEF_W-1:0]      sin_c;
	logic signed [COEF_W-1:0]      cos_c;
	logic signed [COORD_WIDTH-1:0] rot_a;
	logic signed [COORD_WIDTH-1:0] rot_b;
	vat_pkg::op_t                  op;
	logic signed [COEF_W-1:0]      coef_d [vat_pkg::LANES];
	logic signed [COORD_WIDTH-1:0] opnd_d [vat_pkg::LANES];

	// angle modulo 360, cosine as sine of angle plus 90
	always_comb begin
		ang_s      = (angle_q >= 9'd360) ? angle_q - 9'd360 : angle_q;
		ang_c_wide = {1'b0, ang_s} + 10'd90;
		ang_c      = (ang_c_wide >= 10'd360) ? 9'(ang_c_wide - 10'd360) : ang_c_wide[8:0];
		sin_t      = vat_pkg::sine_fold(ang_s);
		cos_t      = vat_pkg::sine_fold(ang_c);
	end

	generate
		if (FRAC_BITS >= vat_pkg::TABLE_FRAC) begin : g_frac_up
			assign sin_f = TRIG_W'(sin_t) <<< (FRAC_BITS - vat_pkg::TABLE_FRAC);
			assign cos_f = TRIG_W'(cos_t) <<< (FRAC_BITS - vat_pkg::TABLE_FRAC);
		end else begin : g_frac_down
			localparam int SH = vat_pkg::TABLE_FRAC - FRAC_BITS;
			localparam logic signed [16:0] HALF = 17'sd1 <<< (SH - 1);
			localparam logic signed [16:0] RND  = (17'sd1 <<< SH) - 17'sd1;
			logic signed [16:0] sin_b;
			logic signed [16:0] cos_b;
			logic signed [16:0] sin_r;
			logic signed [16:0] cos_r;
			// add half an LSB, then divide truncating toward zero
			always_comb begin
				sin_b = 17'(sin_t) + HALF;
				cos_b = 17'(cos_t) + HALF;
				sin_r = (sin_b + (sin_b[16] ? RND : 17'sd0)) >>> SH;
				cos_r = (cos_b + (cos_b[16] ? RND : 17'sd0)) >>> SH;
			end
			assign sin_f = TRIG_W'(sin_r);
			assign cos_f = TRIG_W'(cos_r);
		end
	endgenerate

	assign sin_c = COEF_W'(sin_f);
	assign cos_c = COEF_W'(cos_f);

	always_comb begin
		case (mode_q)
			vat_pkg::MODE_TRANSLATE: op = vat_pkg::OP_TRANSLATE;
			vat_pkg::MODE_SCALE:     op = vat_pkg::OP_SCALE;
			vat_pkg::MODE_ROT_X:     op = vat_pkg::OP_ROT_X;
			vat_pkg::MODE_ROT_Y:     op = vat_pkg::OP_ROT_Y;
			vat_pkg::MODE_ROT_Z:     op = vat_pkg::OP_ROT_Z;
			default:                 op = vat_pkg::OP_IDENT;
		endcase
	end

	// rotation pair: out1 = c*a - s*b, out2 = s*a + c*b
	always_comb begin
		case (op)
			vat_pkg::OP_ROT_X: begin
				rot_a = y_in;
				rot_b = z_in;
			end
			vat_pkg::OP_ROT_Y: begin
				rot_a = z_in;
				rot_b = x_in;
			end
			default: begin
				rot_a = x_in;
				rot_b = y_in;
			end
		endcase
	end

	always_comb begin
		for (int k = 0; k < vat_pkg::LANES; k++) begin
			coef_d[k] = '0;
			opnd_d[k] = '0;
		end
		case (op)
			vat_pkg::OP_TRANSLATE: begin
				coef_d[0] = COEF_W'(param_x_q);
				coef_d[1] = COEF_W'(param_y_q);
				coef_d[2] = COEF_W'(param_z_q);
				opnd_d[0] = w_in;
				opnd_d[1] = w_in;
				opnd_d[2] = w_in;
			end
			vat_pkg::OP_SCALE: begin
				coef_d[0] = COEF_W'(param_x_q);
				coef_d[1] = COEF_W'(param_y_q);
				coef_d[2] = COEF_W'(param_z_q);
				opnd_d[0] = x_in;
				opnd_d[1] = y_in;
				opnd_d[2] = z_in;
			end
			vat_pkg::OP_ROT_X, vat_pkg::OP_ROT_Y, vat_pkg::OP_ROT_Z: begin
				coef_d[0] = cos_c;
				coef_d[1] = sin_c;
				coef_d[2] = sin_c;
				coef_d[3] = cos_c;
				opnd_d[0] = rot_a;
				opnd_d[1] = rot_b;
				opnd_d[2] = rot_a;
				opnd_d[3] = rot_b;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '{valid: 1'b0, op: vat_pkg::OP_IDENT, last: 1'b0};
		end else begin
			ctrl_s1 <= '{valid: start, op: op, last: last_vertex};
		end
	end

	always_ff @(posedge clk) begin
		coef_s1   <= coef_d;
		opnd_s1   <= opnd_d;
		vtx_s1[0] <= x_in;
		vtx_s1[1] <= y_in;
		vtx_s1[2] <= z_in;
		vtx_s1[3] <= w_in;
	end

endmodule

FILE: rtl/vat_mult.sv
// vat_mult: product stage, four signed coefficient by coordinate multipliers
// depends on: vat_pkg
module vat_mult #(
	parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vat_pkg::ctrl_t                        ctrl_s1,
	input  logic signed [vat_pkg::coef_w(FRAC_BITS)-1:0] coef_s1 [vat_pkg::LANES],
	input  logic signed [COORD_WIDTH-1:0]         opnd_s1 [vat_pkg::LANES],
	input  logic signed [COORD_WIDTH-1:0]         vtx_s1 [vat_pkg::LANES],
	output vat_pkg::ctrl_t                        ctrl_s2,
	output logic signed [vat_pkg::coef_w(FRAC_BITS)+COORD_WIDTH-1:0] prod_s2 [vat_pkg::LANES],
	output logic signed [COORD_WIDTH-1:0]         vtx_s2 [vat_pkg::LANES]
);

	localparam int PROD_W = vat_pkg::coef_w(FRAC_BITS) + COORD_WIDTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '{valid: 1'b0, op: vat_pkg::OP_IDENT, last: 1'b0};
		end else begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < vat_pkg::LANES; k++) begin
			prod_s2[k] <= PROD_W'(coef_s1[k]) * PROD_W'(opnd_s1[k]);
		end
		vtx_s2 <= vtx_s1;
	end

endmodule

FILE: rtl/vat_back.sv
// vat_back: result stage; truncates rotation products toward zero, sums rows, saturates to 32 bits
// depends on: vat_pkg
module vat_back #(
	parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  vat_pkg::ctrl_t                        ctrl_s2,
	input  logic signed [vat_pkg::coef_w(FRAC_BITS)+COORD_WIDTH-1:0] prod_s2 [vat_pkg::LANES],
	input  logic signed [COORD_WIDTH-1:0]         vtx_s2 [vat_pkg::LANES],
	output logic                                  done_q,
	output logic                                  last_q,
	output logic signed [vat_pkg::RES_W-1:0]      res_q [vat_pkg::LANES]
);

	localparam int PROD_W = vat_pkg::coef_w(FRAC_BITS) + COORD_WIDTH;
	localparam int SUM_W  = (PROD_W + 2 > vat_pkg::RES_W + 1) ? PROD_W + 2 : vat_pkg::RES_W + 1;
	localparam logic signed [PROD_W:0] RND =
		{{(PROD_W + 1 - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(33'sh0_7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(33'sh1_8000_0000);

	logic signed [PROD_W:0]  prod_b [vat_pkg::LANES];
	logic signed [SUM_W-1:0] prod_w [vat_pkg::LANES];
	logic signed [SUM_W-1:0] trunc_w [vat_pkg::LANES];
	logic signed [SUM_W-1:0] vtx_w [vat_pkg::LANES];
	logic signed [SUM_W-1:0] rot1;
	logic signed [SUM_W-1:0] rot2;
	logic signed [SUM_W-1:0] row [vat_pkg::LANES];
	logic signed [vat_pkg::RES_W-1:0] res_d [vat_pkg::LANES];

	function automatic logic signed [vat_pkg::RES_W-1:0] sat(input logic signed [SUM_W-1:0] v);
		if (v > SAT_MAX) begin
			return vat_pkg::RES_W'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			return vat_pkg::RES_W'(SAT_MIN);
		end
		return vat_pkg::RES_W'(v);
	endfunction

	always_comb begin
		for (int k = 0; k < vat_pkg::LANES; k++) begin
			prod_b[k]  = (PROD_W + 1)'(prod_s2[k]) + (prod_s2[k][PROD_W-1] ? RND : '0);
			trunc_w[k] = SUM_W'(prod_b[k] >>> FRAC_BITS);
			prod_w[k]  = SUM_W'(prod_s2[k]);
			vtx_w[k]   = SUM_W'(vtx_s2[k]);
		end
		rot1 = trunc_w[0] - trunc_w[1];
		rot2 = trunc_w[2] + trunc_w[3];
		row  = vtx_w;
		case (ctrl_s2.op)
			vat_pkg::OP_TRANSLATE: begin
				row[0] = vtx_w[0] + prod_w[0];
				row[1] = vtx_w[1] + prod_w[1];
				row[2] = vtx_w[2] + prod_w[2];
			end
			vat_pkg::OP_SCALE: begin
				row[0] = prod_w[0];
				row[1] = prod_w[1];
				row[2] = prod_w[2];
			end
			vat_pkg::OP_ROT_X: begin
				row[1] = rot1;
				row[2] = rot2;
			end
			vat_pkg::OP_ROT_Y: begin
				row[0] = rot2;
				row[2] = rot1;
			end
			vat_pkg::OP_ROT_Z: begin
				row[0] = rot1;
				row[1] = rot2;
			end
			default: begin
			end
		endcase
		for (int k = 0; k < vat_pkg::LANES; k++) begin
			res_d[k] = sat(row[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		last_q <= ctrl_s2.last;
		res_q  <= res_d;
	end

endmodule

FILE: rtl/vertex_affine_transform_top.sv
// vertex_affine_transform_top: 4x4 homogeneous vertex transform, top level and config registers
// depends on: vat_pkg, vat_front, vat_mult, vat_back
//
// usage
//   a vertex request is taken at each rising edge with start high and busy low;
//   busy is always low, so one vertex can be taken every cycle
//   each result shows on x_out, y_out, z_out, w_out, last_out for one cycle with done
//   high, in request order
//   pipeline: input register, multiplier register, result register,
//   throughput 1 vertex per cycle, set by the four parallel multipliers
//   the receiver cannot stall: done is a strobe and results are never held
//   config writes: cfg_index selects mode, param_x, param_y, param_z, angle_deg
//   (indexes 0 to 4), written when cfg_valid and cfg_ready are high; cfg_ready is
//   always high, other indexes are dropped; write only while no vertex is in flight
//   reset clears all config registers to zero (translate by zero) and drops any
//   vertex in flight; no result appears for requests taken before reset
//   unused mode codes pass the vertex through unchanged
module vertex_affine_transform_top #(
	parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = vat_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [COORD_WIDTH-1:0]      x_in,
	input  logic signed [COORD_WIDTH-1:0]      y_in,
	input  logic signed [COORD_WIDTH-1:0]      z_in,
	input  logic signed [COORD_WIDTH-1:0]      w_in,
	input  logic                               last_vertex,
	output logic                               done,
	output logic signed [vat_pkg::RES_W-1:0]   x_out,
	output logic signed [vat_pkg::RES_W-1:0]   y_out,
	output logic signed [vat_pkg::RES_W-1:0]   z_out,
	output logic signed [vat_pkg::RES_W-1:0]   w_out,
	output logic                               last_out,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [vat_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [vat_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int COEF_W = vat_pkg::coef_w(FRAC_BITS);
	localparam int PROD_W = COEF_W + COORD_WIDTH;

	logic [vat_pkg::MODE_W-1:0]         mode_q;
	logic signed [vat_pkg::PARAM_W-1:0] param_x_q;
	logic signed [vat_pkg::PARAM_W-1:0] param_y_q;
	logic signed [vat_pkg::PARAM_W-1:0] param_z_q;
	logic [vat_pkg::ANGLE_W-1:0]        angle_q;

	vat_pkg::ctrl_t                ctrl_s1;
	vat_pkg::ctrl_t                ctrl_s2;
	logic signed [COEF_W-1:0]      coef_s1 [vat_pkg::LANES];
	logic signed [COORD_WIDTH-1:0] opnd_s1 [vat_pkg::LANES];
	logic signed [COORD_WIDTH-1:0] vtx_s1 [vat_pkg::LANES];
	logic signed [PROD_W-1:0]      prod_s2 [vat_pkg::LANES];
	logic signed [COORD_WIDTH-1:0] vtx_s2 [vat_pkg::LANES];
	logic signed [vat_pkg::RES_W-1:0] res_q [vat_pkg::LANES];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			param_x_q <= '0;
			param_y_q <= '0;
			param_z_q <= '0;
			angle_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				vat_pkg::REG_MODE:    mode_q    <= cfg_data[vat_pkg::MODE_W-1:0];
				vat_pkg::REG_PARAM_X: param_x_q <= $signed(cfg_data);
				vat_pkg::REG_PARAM_Y: param_y_q <= $signed(cfg_data);
				vat_pkg::REG_PARAM_Z: param_z_q <= $signed(cfg_data);
				vat_pkg::REG_ANGLE:   angle_q   <= cfg_data[vat_pkg::ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	vat_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start && !busy),
		.x_in       (x_in),
		.y_in       (y_in),
		.z_in       (z_in),
		.w_in       (w_in),
		.last_vertex(last_vertex),
		.mode_q     (mode_q),
		.param_x_q  (param_x_q),
		.param_y_q  (param_y_q),
		.param_z_q  (param_z_q),
		.angle_q    (angle_q),
		.ctrl_s1    (ctrl_s1),
		.coef_s1    (coef_s1),
		.opnd_s1    (opnd_s1),
		.vtx_s1     (vtx_s1)
	);

	vat_mult #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl_s1(ctrl_s1),
		.coef_s1(coef_s1),
		.opnd_s1(opnd_s1),
		.vtx_s1 (vtx_s1),
		.ctrl_s2(ctrl_s2),
		.prod_s2(prod_s2),
		.vtx_s2 (vtx_s2)
	);

	vat_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl_s2(ctrl_s2),
		.prod_s2(prod_s2),
		.vtx_s2 (vtx_s2),
		.done_q (done),
		.last_q (last_out),
		.res_q  (res_q)
	);

	assign x_out = res_q[0];
	assign y_out = res_q[1];
	assign z_out = res_q[2];
	assign w_out = res_q[3];

endmodule

FILE: rtl/vat_checker.sv
// vat_checker: port-level checks on request to result timing and pass-through fields
// depends on: vat_pkg, bound onto vertex_affine_transform_top
module vat_checker #(
	parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic signed [COORD_WIDTH-1:0]    w_in,
	input logic                             last_vertex,
	input logic                             done,
	input logic signed [vat_pkg::RES_W-1:0] w_out,
	input logic                             last_out
);

	logic signed [vat_pkg::RES_W-1:0] w_ext;
	logic                             req;

	assign w_ext = vat_pkg::RES_W'(w_in);
	assign req   = start && !busy;

	// every request gives a result through the input, multiplier and result registers
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##3 done)
		else $error("request without result");

	// no result without a request that entered the pipeline ahead of it
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(req, 3))
		else $error("result without request");

	// flag follows its vertex
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> last_out == $past(last_vertex, 3))
		else $error("last flag mismatch");

	// bottom row is always 0 0 0 1
	a_w_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> w_out == $past(w_ext, 3))
		else $error("w coordinate changed");

endmodule

bind vertex_affine_transform_top vat_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vat_checker (.*);

FILE: tb/sv/vertex_affine_transform_top_test.sv
// vertex_affine_transform_top_test: self-checking testbench for the 4x4 vertex transform
// depends on: vat_pkg, vertex_affine_transform_top
// predicts each vertex from its own copy of the registers and checks every done strobe
module vertex_affine_transform_top_test;
	import vat_pkg::*;

	localparam int CW          = COORD_WIDTH_DEF;
	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int PIPE_DEPTH  = 3;
	localparam int LIMIT_CYCLES = 500000;
	localparam int RANDOM_ITEMS = 1250;
	localparam int TAIL_ITEMS   = 200;
	localparam int PRINT_MAX    = 25;

	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [PARAM_W-1:0] P_MAX = 16'sh7fff;
	localparam logic signed [PARAM_W-1:0] P_MIN = 16'sh8000;

	typedef struct {
		logic signed [RES_W-1:0] x;
		logic signed [RES_W-1:0] y;
		logic signed [RES_W-1:0] z;
		logic signed [RES_W-1:0] w;
		logic                    last;
	} vertex_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [CW-1:0] x_in, y_in, z_in, w_in;
	logic last_vertex;
	logic done;
	logic signed [RES_W-1:0] x_out, y_out, z_out, w_out;
	logic last_out;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// register copy
	logic [MODE_W-1:0]         cur_mode;
	logic signed [PARAM_W-1:0] cur_px, cur_py, cur_pz;
	logic [ANGLE_W-1:0]        cur_angle;

	vertex_result_t pending_results[$];
	vertex_result_t want;
	int mismatches;
	int vertices_taken;
	int results_checked;
	int reg_writes;
	int saturated;
	bit idle_on;

	// round(16384 * sin(d degrees)) for d = 0..90
	int sine_deg_q14 [0:90] = '{
		0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
		2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
		5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
		8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
		10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
		12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
		14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
		15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
		16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
		16384
	};

	vertex_affine_transform_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.x_in(x_in), .y_in(y_in), .z_in(z_in), .w_in(w_in), .last_vertex(last_vertex),
		.done(done), .x_out(x_out), .y_out(y_out), .z_out(z_out), .w_out(w_out),
		.last_out(last_out), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic longint trig_q(input int deg);
		int     d;
		longint t;
		d = deg % 360;
		if (d <= 90)
			t = sine_deg_q14[d];
		else if (d <= 180)
			t = sine_deg_q14[180 - d];
		else if (d <= 270)
			t = -sine_deg_q14[d - 180];
		else
			t = -sine_deg_q14[360 - d];
		return t * (longint'(1) << (FRAC - TABLE_FRAC));
	endfunction

	function automatic vertex_result_t transform_vertex(input logic signed [CW-1:0] vx,
			input logic signed [CW-1:0] vy, input logic signed [CW-1:0] vz,
			input logic signed [CW-1:0] vw, input logic vlast);
		longint m [4][4];
		longint c [4];
		longint o [4];
		longint one, s, co, p, acc;
		bit     frac;
		vertex_result_t r;
		c[0] = vx; c[1] = vy; c[2] = vz; c[3] = vw;
		one = longint'(1) << FRAC;
		frac = 0;
		for (int i = 0; i < 4; i++)
			for (int k = 0; k < 4; k++)
				m[i][k] = (i == k) ? 1 : 0;
		s = trig_q(int'(cur_angle));
		co = trig_q(int'(cur_angle) + 90);
		case (cur_mode)
			MODE_TRANSLATE: begin
				m[0][3] = cur_px; m[1][3] = cur_py; m[2][3] = cur_pz;
			end
			MODE_SCALE: begin
				m[0][0] = cur_px; m[1][1] = cur_py; m[2][2] = cur_pz;
			end
			MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z: begin
				frac = 1;
				for (int i = 0; i < 4; i++)
					m[i][i] = one;
				if (cur_mode == MODE_ROT_X) begin
					m[1][1] = co; m[1][2] = -s; m[2][1] = s; m[2][2] = co;
				end else if (cur_mode == MODE_ROT_Y) begin
					m[0][0] = co; m[0][2] = s; m[2][0] = -s; m[2][2] = co;
				end else begin
					m[0][0] = co; m[0][1] = -s; m[1][0] = s; m[1][1] = co;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) begin
			acc = 0;
			for (int k = 0; k < 4; k++) begin
				p = m[i][k] * c[k];
				if (frac)
					p = p / one;
				acc += p;
			end
			if (acc > 64'sd2147483647) begin
				acc = 64'sd2147483647;
				saturated++;
			end else if (acc < -64'sd2147483648) begin
				acc = -64'sd2147483648;
				saturated++;
			end
			o[i] = acc;
		end
		r.x = o[0][RES_W-1:0];
		r.y = o[1][RES_W-1:0];
		r.z = o[2][RES_W-1:0];
		r.w = o[3][RES_W-1:0];
		r.last = vlast;
		return r;
	endfunction

	task automatic report(input string text);
		mismatches++;
		if (mismatches <= PRINT_MAX)
			$display("mismatch at %0t: %s", $realtime, text);
	endtask

	// result checker and request monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("result with no request waiting");
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (x_out !== want.x)
					report($sformatf("x_out %0d, want %0d", x_out, want.x));
				if (y_out !== want.y)
					report($sformatf("y_out %0d, want %0d", y_out, want.y));
				if (z_out !== want.z)
					report($sformatf("z_out %0d, want %0d", z_out, want.z));
				if (w_out !== want.w)
					report($sformatf("w_out %0d, want %0d", w_out, want.w));
				if (last_out !== want.last)
					report($sformatf("last_out %b, want %b", last_out, want.last));
			end
		end
		if (arst_n && start && busy === 1'b0) begin
			pending_results.push_back(transform_vertex(x_in, y_in, z_in, w_in, last_vertex));
			vertices_taken++;
		end
	end

	task automatic send_vertex(input logic signed [CW-1:0] vx, input logic signed [CW-1:0] vy,
			input logic signed [CW-1:0] vz, input logic signed [CW-1:0] vw, input logic vlast);
		@(negedge clk);
		start <= 1'b1;
		x_in <= vx;
		y_in <= vy;
		z_in <= vz;
		w_in <= vw;
		last_vertex <= vlast;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic hold_off(input int n);
		@(negedge clk);
		start <= 1'b0;
		x_in <= CW'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		reg_writes++;
		case (idx)
			REG_MODE:    cur_mode = data[MODE_W-1:0];
			REG_PARAM_X: cur_px = data;
			REG_PARAM_Y: cur_py = data;
			REG_PARAM_Z: cur_pz = data;
			REG_ANGLE:   cur_angle = data[ANGLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_transform(input logic [MODE_W-1:0] mode, input logic signed [PARAM_W-1:0] px,
			input logic signed [PARAM_W-1:0] py, input logic signed [PARAM_W-1:0] pz,
			input int angle);
		write_reg(REG_MODE, CFG_DATA_W'(mode));
		write_reg(REG_PARAM_X, px);
		write_reg(REG_PARAM_Y, py);
		write_reg(REG_PARAM_Z, pz);
		write_reg(REG_ANGLE, CFG_DATA_W'(angle));
	endtask

	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return C_MAX;
			1: return C_MIN;
			2: return CW'($urandom_range(0, 2000)) - CW'(1000);
			3: return CW'($urandom_range(0, 2)) - CW'(1);
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic signed [PARAM_W-1:0] pick_param();
		case ($urandom_range(0, 5))
			0: return P_MAX;
			1: return P_MIN;
			2: return PARAM_W'($urandom_range(0, 20)) - PARAM_W'(10);
			default: return PARAM_W'($urandom);
		endcase
	endfunction

	task automatic send_random_vertex();
		logic signed [CW-1:0] vw;
		vw = ($urandom_range(0, 1) == 0) ? CW'(1) : pick_coord();
		send_vertex(pick_coord(), pick_coord(), pick_coord(), vw, 1'($urandom));
		if (idle_on && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 9));
	endtask

	// registers come out of reset as translate by zero
	task automatic test_reset_values();
		send_vertex(C_MAX, C_MIN, 24'sd12345, 24'sd1, 1'b0);
		send_vertex(C_MIN, C_MAX, -24'sd7, C_MAX, 1'b1);
		drain_results();
	endtask

	task automatic test_corner_vertices();
		set_transform(MODE_TRANSLATE, P_MAX, P_MIN, 16'sd0, 0);
		send_vertex(24'sd1, 24'sd2, 24'sd3, 24'sd1, 1'b0);
		send_vertex(C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
		send_vertex(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
		drain_results();
		set_transform(MODE_SCALE, P_MIN, P_MAX, -16'sd1, 0);
		send_vertex(C_MIN, C_MAX, C_MIN, 24'sd1, 1'b1);
		send_vertex(C_MAX, C_MIN, 24'sd0, -24'sd1, 1'b0);
		drain_results();
		set_transform(MODE_ROT_X, 16'sd0, 16'sd0, 16'sd0, 90);
		send_vertex(24'sd1000, 24'sd2000, 24'sd3000, 24'sd1, 1'b0);
		send_vertex(C_MAX, C_MIN, C_MAX, 24'sd1, 1'b1);
		drain_results();
		set_transform(MODE_ROT_Y, 16'sd0, 16'sd0, 16'sd0, 45);
		send_vertex(C_MAX, 24'sd0, C_MIN, 24'sd1, 1'b0);
		send_vertex(-24'sd3, 24'sd5, 24'sd3, C_MIN, 1'b1);
		drain_results();
		set_transform(MODE_ROT_Z, 16'sd0, 16'sd0, 16'sd0, 270);
		send_vertex(C_MIN, C_MAX, 24'sd77, 24'sd1, 1'b0);
		drain_results();
		write_reg(REG_ANGLE, 16'd180);
		send_vertex(24'sd12345, -24'sd54321, 24'sd9, 24'sd1, 1'b0);
		drain_results();
		// angles past 359 wrap
		write_reg(REG_ANGLE, 16'd360);
		send_vertex(C_MAX, C_MAX, 24'sd1, 24'sd1, 1'b0);
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_ROT_Y));
		write_reg(REG_ANGLE, 16'd511);
		send_vertex(C_MAX, C_MIN, C_MIN, 24'sd1, 1'b1);
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_ROT_X));
		write_reg(REG_ANGLE, 16'd359);
		send_vertex(24'sd100000, C_MAX, C_MIN, 24'sd1, 1'b0);
		drain_results();
		// unused mode codes pass the vertex through
		for (int md = int'(MODE_ROT_Z) + 1; md < (1 << MODE_W); md++) begin
			write_reg(REG_MODE, CFG_DATA_W'(md));
			send_vertex(C_MAX, C_MIN, -24'sd1, 24'sd42, 1'($urandom));
			drain_results();
		end
		// writes to spare indexes must not touch any register
		set_transform(MODE_TRANSLATE, 16'sd5, -16'sd6, 16'sd7, 0);
		for (int idx = int'(REG_ANGLE) + 1; idx < (1 << CFG_INDEX_W); idx++)
			write_reg(CFG_INDEX_W'(idx), 16'hffff);
		send_vertex(24'sd10, 24'sd20, 24'sd30, 24'sd2, 1'b1);
		drain_results();
	endtask

	task automatic test_random_phases();
		int n;
		while (vertices_taken < RANDOM_ITEMS) begin
			write_reg(REG_MODE, ($urandom_range(0, 9) < 8) ?
				CFG_DATA_W'($urandom_range(0, int'(MODE_ROT_Z))) : CFG_DATA_W'($urandom));
			write_reg(REG_PARAM_X, pick_param());
			write_reg(REG_PARAM_Y, pick_param());
			write_reg(REG_PARAM_Z, pick_param());
			write_reg(REG_ANGLE, ($urandom_range(0, 3) == 0) ?
				CFG_DATA_W'($urandom) : CFG_DATA_W'($urandom_range(0, 359)));
			if ($urandom_range(0, 4) == 0)
				write_reg(CFG_INDEX_W'($urandom_range(int'(REG_ANGLE) + 1, (1 << CFG_INDEX_W) - 1)),
					CFG_DATA_W'($urandom));
			idle_on = $urandom_range(0, 2) != 0;
			n = $urandom_range(10, 60);
			repeat (n)
				send_random_vertex();
			drain_results();
		end
	endtask

	task automatic test_streaming_tail();
		set_transform(MODE_ROT_Z, pick_param(), pick_param(), pick_param(), $urandom_range(0, 359));
		idle_on = 0;
		repeat (TAIL_ITEMS)
			send_random_vertex();
		drain_results();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		x_in = '0;
		y_in = '0;
		z_in = '0;
		w_in = '0;
		last_vertex = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_mode = '0;
		cur_px = '0;
		cur_py = '0;
		cur_pz = '0;
		cur_angle = '0;
		mismatches = 0;
		vertices_taken = 0;
		results_checked = 0;
		reg_writes = 0;
		saturated = 0;
		idle_on = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_corner_vertices();
		test_random_phases();
		test_streaming_tail();

		if (pending_results.size() != 0)
			report($sformatf("%0d results never came", pending_results.size()));
		$display("covered %0d vertices and %0d register writes over all modes and wrapped angles",
			vertices_taken, reg_writes);
		$display("%0d results checked, %0d coordinates saturated", results_checked, saturated);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 20);
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("simulation failed");
		$finish;
	end

endmodule
